// ===== hdl/ttce_pkg.sv =====
// Shared constants, codes and types of the text terminal character engine.
package ttce_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths
  localparam int ADDR_W = 11;
  localparam int CHAR_W = 8;
  localparam int ACT_W  = 2;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int COL_W  = $clog2(COLUMNS);

  // Tab stops fall on multiples of a power of two
  localparam int TAB_STOP = 8;
  localparam int TAB_W    = $clog2(TAB_STOP);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_CLEAR,
    ST_SCROLL,
    ST_RESULT
  } state_t;

  // What a put does to the store, known in the cycle it is taken
  typedef struct packed {
    logic store;
    logic scroll;
  } cur_info_t;

endpackage

// ===== hdl/ttce_if.sv =====
// Request and response channel interfaces of the text terminal character engine.
interface ttce_req_if import ttce_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] read_address;

  modport source (output valid, output action, output char_code, output read_address,
                  input ready);
  modport sink   (input valid, input action, input char_code, input read_address,
                  output ready);
endinterface

interface ttce_rsp_if import ttce_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] cursor_position;
  logic [CHAR_W-1:0] read_char;
  logic              scrolled;

  modport source (output valid, output cursor_position, output read_char,
                  output scrolled, input ready);
  modport sink   (input valid, input cursor_position, input read_char,
                  input scrolled, output ready);
endinterface

// ===== hdl/text_terminal_char_engine_top.sv =====
// Top level of the text terminal character engine: sequencer, screen RAM and cursor unit.
// A character screen of COLUMNS x ROWS cells sits in one RAM with a single address
// counter that sweeps it. After reset the block fills the RAM with spaces before
// request.ready first rises. Every request beat gives one response beat. A put that
// does not scroll, and the unused action code, pass from the accept state to the
// result state; a read passes through a wait state for the registered RAM read between
// the two. A clear sweeps the RAM once, and a put that scrolls makes one copy pass of
// one cell a cycle, before the result state.
// A response held by response.ready stalls the next request until it is taken.
module text_terminal_char_engine_top import ttce_pkg::*; (
  input logic        clk,
  input logic        rst,
  ttce_req_if.sink   request,
  ttce_rsp_if.source response
);

  localparam logic [CNT_W-1:0] CELLS_C   = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] COLS_C    = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] COPY_LAST = CNT_W'(CELLS - COLUMNS);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] cnt_plus;
  logic [CNT_W-1:0] cnt_minus;

  logic              in_beat;
  logic              put_step;
  action_t           act;
  logic [ADDR_W-1:0] cursor;
  cur_info_t         info;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;

  logic              read_ok;
  logic [CHAR_W-1:0] res_char;
  logic              res_scr;
  logic              out_load;

  logic              rsp_valid;
  logic [ADDR_W-1:0] rsp_cursor;
  logic [CHAR_W-1:0] rsp_char;
  logic              rsp_scr;

  assign request.ready = (state == ST_IDLE);
  assign in_beat       = request.valid && request.ready;
  assign act           = action_t'(request.action);
  assign put_step      = in_beat && (act == ACT_PUT);

  assign cnt_plus  = cnt + COLS_C;
  assign cnt_minus = cnt - 1'b1;

  ttce_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .step      (put_step),
    .char_code (request.char_code),
    .cursor    (cursor),
    .info      (info)
  );

  ttce_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold sequencer state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Sequence actions and drive the RAM ports
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    wr_en      = 1'b0;
    wr_addr    = cnt[ADDR_W-1:0];
    wr_data    = CHAR_SPACE;
    rd_addr    = request.read_address;
    out_load   = 1'b0;
    case (state)
      ST_INIT: begin
        wr_en = 1'b1;
        if (cnt == CELLS_C - 1'b1) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          cnt_next = '0;
          case (act)
            ACT_PUT: begin
              wr_en      = info.store;
              wr_addr    = cursor;
              wr_data    = request.char_code;
              state_next = info.scroll ? ST_SCROLL : ST_RESULT;
            end
            ACT_READ:  state_next = ST_READ_WAIT;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_READ_WAIT: begin
        state_next = ST_RESULT;
      end
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (cnt == CELLS_C - 1'b1) begin
          state_next = ST_RESULT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCROLL: begin
        // Read one row ahead, write the cell read last cycle one step behind
        rd_addr = cnt_plus[ADDR_W-1:0];
        wr_en   = (cnt != '0);
        wr_addr = cnt_minus[ADDR_W-1:0];
        wr_data = (cnt <= COPY_LAST) ? rd_data : CHAR_SPACE;
        if (cnt == CELLS_C) begin
          state_next = ST_RESULT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || response.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the result fields of the action in progress
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_char <= '0;
      res_scr  <= (act == ACT_PUT) && info.scroll;
      read_ok  <= ({1'b0, request.read_address} < CELLS_C);
    end
    if (state == ST_READ_WAIT) begin
      res_char <= read_ok ? rd_data : '0;
    end
  end

  // Output register: load the result beat, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (response.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_cursor <= cursor;
      rsp_char   <= res_char;
      rsp_scr    <= res_scr;
    end
  end

  assign response.valid           = rsp_valid;
  assign response.cursor_position = rsp_cursor;
  assign response.read_char       = rsp_char;
  assign response.scrolled        = rsp_scr;

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    response.valid |-> ({1'b0, response.cursor_position} < CELLS_C))
    else $error("cursor position beyond the screen");

  a_scroll_no_char: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.scrolled) |-> (response.read_char == '0))
    else $error("scrolled beat carries read data");

  a_idle_write_is_put: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == ST_IDLE) |-> (in_beat && act == ACT_PUT))
    else $error("RAM write in idle without a put beat");

  a_scroll_starts: assert property (@(posedge clk) disable iff (rst)
    (put_step && info.scroll) |=> (state == ST_SCROLL && cnt == '0))
    else $error("scrolling put did not start the copy pass");
`endif

endmodule

// ===== hdl/ttce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/ttce_cursor.sv =====
// Cursor unit: linear cursor, column and row start, updated by one put per step.
module ttce_cursor import ttce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_code,
  output logic [ADDR_W-1:0] cursor,
  output cur_info_t         info
);

  localparam logic [CNT_W-1:0] COLS_W  = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] CELLS_W = CNT_W'(CELLS);
  localparam logic [COL_W:0]   COLS_C  = (COL_W+1)'(COLUMNS);

  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] row_start;

  logic [CNT_W-1:0] cur_w;
  logic [CNT_W-1:0] rs_w;
  logic [CNT_W-1:0] nc;
  logic [CNT_W-1:0] nrs;
  logic [COL_W-1:0] ncol;
  logic [COL_W:0]   col_sum;
  logic [TAB_W:0]   adv;
  logic             printable;

  // Work out the next cursor, column and row start; the column is tracked so that
  // no remainder by the row length is needed
  always_comb begin
    cur_w     = {1'b0, cursor};
    rs_w      = {1'b0, row_start};
    printable = char_code inside {[CHAR_SPACE:CHAR_LAST]};
    adv       = '0;
    col_sum   = '0;
    nc        = cur_w;
    nrs       = rs_w;
    ncol      = col;
    if (char_code == CHAR_BS) begin
      // Backspace stops at the first cell
      if (cursor != '0) begin
        nc = cur_w - 1'b1;
        if (col == '0) begin
          ncol = COL_W'(COLUMNS - 1);
          nrs  = rs_w - COLS_W;
        end else begin
          ncol = col - 1'b1;
        end
      end
    end else if (char_code == CHAR_TAB || printable) begin
      adv = printable ? (TAB_W+1)'(1)
                      : (TAB_W+1)'(TAB_STOP) - {1'b0, cursor[TAB_W-1:0]};
      nc      = cur_w + CNT_W'(adv);
      col_sum = {1'b0, col} + (COL_W+1)'(adv);
      if (col_sum >= COLS_C) begin
        ncol = COL_W'(col_sum - COLS_C);
        nrs  = rs_w + COLS_W;
      end else begin
        ncol = col_sum[COL_W-1:0];
      end
    end else if (char_code == CHAR_CR) begin
      nc   = rs_w;
      ncol = '0;
    end else if (char_code == CHAR_LF) begin
      nc   = rs_w + COLS_W;
      nrs  = rs_w + COLS_W;
      ncol = '0;
    end
    info.store  = printable;
    info.scroll = (nc >= CELLS_W);
    // Past the end: pull back one row to follow the scroll
    if (info.scroll) begin
      nc  = nc - COLS_W;
      nrs = nrs - COLS_W;
    end
  end

  // Hold cursor state; advance on a put
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      col       <= '0;
      row_start <= '0;
    end else if (step) begin
      cursor    <= nc[ADDR_W-1:0];
      col       <= ncol;
      row_start <= nrs[ADDR_W-1:0];
    end
  end

endmodule
